>>> sv/ipbd_pkg.sv
// ----------------------------------------------------------------------------
// ipbd_pkg
// Shared codes and chunk identifiers for the IFF ILBM/PBM ByteRun1 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ipbd_pkg;

  // Big-endian four-character codes as they arrive on the byte stream
  localparam logic [31:0] ID_FORM = 32'h464F524D;
  localparam logic [31:0] ID_ILBM = 32'h494C424D;
  localparam logic [31:0] ID_PBM  = 32'h50424D20;
  localparam logic [31:0] ID_BODY = 32'h424F4459;
  localparam logic [31:0] ID_CMAP = 32'h434D4150;

  localparam logic [31:0] CMAP_BYTES   = 32'd768;
  localparam logic [7:0]  CTRL_NOP     = 8'h80;
  localparam logic [8:0]  REPEAT_BASE  = 9'd257;
  localparam logic [31:0] FORM_TYPE_SZ = 32'd4;

  typedef enum logic [3:0] {
    PH_FORM  = 4'd0,
    PH_FSIZE = 4'd1,
    PH_FTYPE = 4'd2,
    PH_CNAME = 4'd3,
    PH_CSIZE = 4'd4,
    PH_DATA  = 4'd5,
    PH_PAD   = 4'd6,
    PH_DPEND = 4'd7,
    PH_HALT  = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    CL_OTHER = 2'd0,
    CL_CMAP  = 2'd1,
    CL_BODY  = 2'd2
  } chunk_class_t;

  typedef enum logic [1:0] {
    RM_CTRL = 2'd0,
    RM_LIT  = 2'd1,
    RM_REP  = 2'd2,
    RM_SKIP = 2'd3
  } run_mode_t;

  typedef enum logic [2:0] {
    KIND_PIXEL    = 3'd0,
    KIND_PALETTE  = 3'd1,
    KIND_DONE     = 3'd2,
    KIND_BAD_FORM = 3'd3,
    KIND_BAD_TYPE = 3'd4,
    KIND_TRUNC    = 3'd5
  } kind_t;

  typedef enum logic [0:0] {
    REG_PALETTE_ENABLE = 1'd0,
    REG_IMAGE_ENABLE   = 1'd1
  } reg_index_t;

endpackage

`default_nettype wire

>>> sv/iff_pbm_byterun_decoder.sv
// A result is registered: it appears on out_* in the cycle after the byte that causes it is transferred.
// Throughput: one byte per cycle; the parser state updates in a single pass per byte. A byte
//   is held off only while a result waits in the output register and out_ready is low.
// A finish result due on a byte that already yields a result takes the next byte's slot (that byte is dropped).
// Reset (rst_n low, synchronous): parser back to awaiting the FORM id, output empty,
//   palette_enable and image_enable set to 1.
// ----------------------------------------------------------------------------
// iff_pbm_byterun_decoder
// Parses an IFF ILBM/PBM byte stream, emits CMAP palette bytes and decodes
// the BODY chunk as ByteRun1 runs.
// ----------------------------------------------------------------------------
`default_nettype none

module iff_pbm_byterun_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte stream
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_file_start,
  // results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_value,
  output logic [7:0]       out_run_length,
  output logic [9:0]       out_palette_slot,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic        cfg_data
);

  typedef struct packed {
    ipbd_pkg::phase_t       phase;
    logic [1:0]             fbi;
    logic [23:0]            gather;
    logic [31:0]            form_rem;
    ipbd_pkg::chunk_class_t cls;
    logic [31:0]            chunk_rem;
    logic                   odd;
    logic                   seen_pal;
    logic                   seen_body;
    ipbd_pkg::run_mode_t    rmode;
    logic [7:0]             lit_left;
    logic [7:0]             rep_cnt;
    logic [9:0]             pal_pos;
    logic                   pal_acc;
  } st_t;

  localparam st_t ST_RESET = '{
    phase:     ipbd_pkg::PH_FORM,
    fbi:       '0,
    gather:    '0,
    form_rem:  '0,
    cls:       ipbd_pkg::CL_OTHER,
    chunk_rem: '0,
    odd:       1'b0,
    seen_pal:  1'b0,
    seen_body: 1'b0,
    rmode:     ipbd_pkg::RM_CTRL,
    lit_left:  '0,
    rep_cnt:   '0,
    pal_pos:   '0,
    pal_acc:   1'b0
  };

  st_t             st_r, st_nxt;
  logic            pal_en_r, img_en_r;
  logic            out_valid_r;
  ipbd_pkg::kind_t out_kind_r;
  logic [7:0]      out_value_r, out_run_length_r;
  logic [9:0]      out_slot_r;

  logic            in_fire;
  logic            res_emit;
  ipbd_pkg::kind_t res_kind;
  logic [7:0]      res_value, res_rl;
  logic [9:0]      res_slot;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    st_t         s;
    logic [31:0] word;
    logic        last;
    logic        chunk_end;
    s         = in_file_start ? ST_RESET : st_r;
    word      = {s.gather, in_byte};
    last      = (s.chunk_rem == 32'd1);
    chunk_end = 1'b0;
    res_emit  = 1'b0;
    res_kind  = ipbd_pkg::KIND_PIXEL;
    res_value = '0;
    res_rl    = '0;
    res_slot  = '0;

    unique case (s.phase)
      ipbd_pkg::PH_FORM, ipbd_pkg::PH_FSIZE, ipbd_pkg::PH_FTYPE,
      ipbd_pkg::PH_CNAME, ipbd_pkg::PH_CSIZE: begin
        // chunk headers count against the form, the form header does not
        if (s.phase == ipbd_pkg::PH_CNAME || s.phase == ipbd_pkg::PH_CSIZE) begin
          s.form_rem = (s.form_rem != 32'd0) ? s.form_rem - 32'd1 : 32'd0;
        end
        s.gather = word[23:0];
        if (s.fbi != 2'd3) begin
          s.fbi = s.fbi + 2'd1;
        end else begin
          s.fbi = 2'd0;
          if (s.phase == ipbd_pkg::PH_FORM) begin
            if (word != ipbd_pkg::ID_FORM) begin
              res_emit = 1'b1;
              res_kind = ipbd_pkg::KIND_BAD_FORM;
              s.phase  = ipbd_pkg::PH_HALT;
            end else begin
              s.phase = ipbd_pkg::PH_FSIZE;
            end
          end else if (s.phase == ipbd_pkg::PH_FSIZE) begin
            s.form_rem = word;
            s.phase    = ipbd_pkg::PH_FTYPE;
          end else if (s.phase == ipbd_pkg::PH_FTYPE) begin
            if (word != ipbd_pkg::ID_ILBM && word != ipbd_pkg::ID_PBM) begin
              res_emit = 1'b1;
              res_kind = ipbd_pkg::KIND_BAD_TYPE;
              s.phase  = ipbd_pkg::PH_HALT;
            end else begin
              s.form_rem = (s.form_rem >= ipbd_pkg::FORM_TYPE_SZ) ?
                           s.form_rem - ipbd_pkg::FORM_TYPE_SZ : 32'd0;
              s.phase    = ipbd_pkg::PH_CNAME;
            end
          end else if (s.phase == ipbd_pkg::PH_CNAME) begin
            s.cls   = (word == ipbd_pkg::ID_CMAP) ? ipbd_pkg::CL_CMAP :
                      (word == ipbd_pkg::ID_BODY) ? ipbd_pkg::CL_BODY : ipbd_pkg::CL_OTHER;
            s.phase = ipbd_pkg::PH_CSIZE;
          end else begin
            s.chunk_rem = word;
            s.odd       = word[0];
            s.pal_acc   = 1'b0;
            s.rmode     = ipbd_pkg::RM_CTRL;
            if (s.cls == ipbd_pkg::CL_CMAP) begin
              s.seen_pal = 1'b1;
              s.pal_acc  = pal_en_r && (word == ipbd_pkg::CMAP_BYTES);
              s.pal_pos  = '0;
            end else if (s.cls == ipbd_pkg::CL_BODY) begin
              s.seen_body = 1'b1;
              s.rmode     = img_en_r ? ipbd_pkg::RM_CTRL : ipbd_pkg::RM_SKIP;
            end
            if (word == 32'd0) chunk_end = 1'b1;
            else               s.phase   = ipbd_pkg::PH_DATA;
          end
        end
      end
      ipbd_pkg::PH_DATA: begin
        s.form_rem  = (s.form_rem != 32'd0) ? s.form_rem - 32'd1 : 32'd0;
        s.chunk_rem = s.chunk_rem - 32'd1;
        if (s.cls == ipbd_pkg::CL_CMAP && s.pal_acc) begin
          res_emit  = 1'b1;
          res_kind  = ipbd_pkg::KIND_PALETTE;
          res_value = in_byte;
          res_slot  = s.pal_pos;
          s.pal_pos = s.pal_pos + 10'd1;
        end else if (s.cls == ipbd_pkg::CL_BODY) begin
          unique case (s.rmode)
            ipbd_pkg::RM_CTRL: begin
              if (in_byte != ipbd_pkg::CTRL_NOP) begin
                if (in_byte[7]) begin
                  s.rep_cnt = 8'(ipbd_pkg::REPEAT_BASE - {1'b0, in_byte});
                  s.rmode   = ipbd_pkg::RM_REP;
                end else begin
                  s.lit_left = in_byte + 8'd1;
                  s.rmode    = ipbd_pkg::RM_LIT;
                end
                // control byte with nothing left to follow it
                if (last) begin
                  res_emit = 1'b1;
                  res_kind = ipbd_pkg::KIND_TRUNC;
                end
              end
            end
            ipbd_pkg::RM_REP: begin
              res_emit  = 1'b1;
              res_value = in_byte;
              res_rl    = s.rep_cnt;
              s.rmode   = ipbd_pkg::RM_CTRL;
            end
            ipbd_pkg::RM_LIT: begin
              s.lit_left = s.lit_left - 8'd1;
              res_emit   = 1'b1;
              res_value  = in_byte;
              res_rl     = 8'd1;
              if (s.lit_left == 8'd0) s.rmode = ipbd_pkg::RM_CTRL;
              else if (last)          res_kind = ipbd_pkg::KIND_TRUNC;
            end
            ipbd_pkg::RM_SKIP: begin
            end
          endcase
        end
        if (last) begin
          if (s.odd) begin
            s.rmode = ipbd_pkg::RM_CTRL;
            s.phase = ipbd_pkg::PH_PAD;
          end else begin
            chunk_end = 1'b1;
          end
        end
      end
      ipbd_pkg::PH_PAD: begin
        s.form_rem = (s.form_rem != 32'd0) ? s.form_rem - 32'd1 : 32'd0;
        chunk_end  = 1'b1;
      end
      ipbd_pkg::PH_DPEND: begin
        res_emit = 1'b1;
        res_kind = ipbd_pkg::KIND_DONE;
        s.phase  = ipbd_pkg::PH_HALT;
      end
      default: begin
        // halted: drop bytes until a new file starts
      end
    endcase

    if (chunk_end) begin
      s.rmode = ipbd_pkg::RM_CTRL;
      if (s.form_rem == 32'd0 || (s.seen_pal && s.seen_body)) begin
        // defer the finish result when this byte already produced one
        if (res_emit) begin
          s.phase = ipbd_pkg::PH_DPEND;
        end else begin
          res_emit = 1'b1;
          res_kind = ipbd_pkg::KIND_DONE;
          s.phase  = ipbd_pkg::PH_HALT;
        end
      end else begin
        s.phase = ipbd_pkg::PH_CNAME;
      end
    end

    st_nxt = in_fire ? s : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RESET;
      pal_en_r    <= 1'b1;
      img_en_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (ipbd_pkg::reg_index_t'(cfg_index))
          ipbd_pkg::REG_PALETTE_ENABLE: pal_en_r <= cfg_data;
          ipbd_pkg::REG_IMAGE_ENABLE:   img_en_r <= cfg_data;
        endcase
      end
      if (in_fire && res_emit) out_valid_r <= 1'b1;
      else if (out_ready)      out_valid_r <= 1'b0;
    end
  end

  // result payload: load on transfer of a byte that yields a result
  always_ff @(posedge clk) begin
    if (in_fire && res_emit) begin
      out_kind_r       <= res_kind;
      out_value_r      <= res_value;
      out_run_length_r <= res_rl;
      out_slot_r       <= res_slot;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_value        = out_value_r;
  assign out_run_length   = out_run_length_r;
  assign out_palette_slot = out_slot_r;

  a_pixel_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == ipbd_pkg::KIND_PIXEL) |->
      (out_run_length != 8'd0 && out_run_length <= 8'd128))
    else $error("pixel run length out of range");

  a_palette_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == ipbd_pkg::KIND_PALETTE) |-> (out_palette_slot < 10'd768))
    else $error("palette slot beyond table");

  a_halt_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_emit && res_kind == ipbd_pkg::KIND_DONE) |=>
      (st_r.phase == ipbd_pkg::PH_HALT))
    else $error("parser not halted after finish result");

  a_literal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.rmode == ipbd_pkg::RM_LIT) |-> (st_r.lit_left != 8'd0))
    else $error("literal mode with no bytes left");

endmodule

`default_nettype wire
